@@ rtl/c6502_pkg.sv @@
`timescale 1ns / 1ps
package c6502_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] AccReset   = 8'h00;
  localparam logic [7:0] SpReset    = 8'hFD;
  localparam logic [7:0] FlagsReset = 8'h34;
  localparam logic [7:0] StackPage  = 8'h01;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  typedef enum logic [5:0] {
    OpAdc = 6'd0,  OpAnd = 6'd1,  OpAsl = 6'd2,  OpBcc = 6'd3,  OpBcs = 6'd4,
    OpBeq = 6'd5,  OpBit = 6'd6,  OpBmi = 6'd7,  OpBne = 6'd8,  OpBpl = 6'd9,
    OpBrk = 6'd10, OpBvc = 6'd11, OpBvs = 6'd12, OpClc = 6'd13, OpCld = 6'd14,
    OpCli = 6'd15, OpClv = 6'd16, OpCmp = 6'd17, OpCpx = 6'd18, OpCpy = 6'd19,
    OpDec = 6'd20, OpDex = 6'd21, OpDey = 6'd22, OpEor = 6'd23, OpInc = 6'd24,
    OpInx = 6'd25, OpIny = 6'd26, OpJmp = 6'd27, OpJsr = 6'd28, OpLda = 6'd29,
    OpLdx = 6'd30, OpLdy = 6'd31, OpLsr = 6'd32, OpNop = 6'd33, OpOra = 6'd34,
    OpPha = 6'd35, OpPhp = 6'd36, OpPla = 6'd37, OpPlp = 6'd38, OpRol = 6'd39,
    OpRor = 6'd40, OpRti = 6'd41, OpRts = 6'd42, OpSbc = 6'd43, OpSec = 6'd44,
    OpSed = 6'd45, OpSei = 6'd46, OpSta = 6'd47, OpStx = 6'd48, OpSty = 6'd49,
    OpTax = 6'd50, OpTay = 6'd51, OpTsx = 6'd52, OpTxa = 6'd53, OpTxs = 6'd54,
    OpTya = 6'd55, OpNone = 6'd56
  } op_e;

  // Classified operation handed from front to back
  typedef struct packed {
    op_e         op;
    logic        to_acc;
    logic [7:0]  operand;
    logic [15:0] addr;
  } uop_t;

endpackage

@@ rtl/c6502_front.sv @@
`timescale 1ns / 1ps
module c6502_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [5:0]        mode_i,
  input  logic              to_accumulator_i,
  input  logic [7:0]        operand_i,
  input  logic [15:0]       operand_address_i,
  output logic              uop_valid_o,
  input  logic              uop_ready_i,
  output c6502_pkg::uop_t   uop_o
);

  localparam int unsigned PtrW = $clog2(c6502_pkg::QueueDepth);

  c6502_pkg::uop_t   mem_q [c6502_pkg::QueueDepth];
  c6502_pkg::uop_t   in_uop;
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push, pop;

  // Classify: fold unused codes onto the no-op
  always_comb begin
    in_uop.op      = (mode_i > 6'(c6502_pkg::OpNone)) ? c6502_pkg::OpNone
                                                      : c6502_pkg::op_e'(mode_i);
    in_uop.to_acc  = to_accumulator_i;
    in_uop.operand = operand_i;
    in_uop.addr    = operand_address_i;
  end

  assign ready_o     = cnt_q != (PtrW+1)'(c6502_pkg::QueueDepth);
  assign uop_valid_o = cnt_q != '0;
  assign uop_o       = mem_q[rd_q];
  assign push        = valid_i && ready_o;
  assign pop         = uop_valid_o && uop_ready_i;

  // Advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(c6502_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(c6502_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_uop;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(c6502_pkg::QueueDepth))
    else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance");
  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q)
    else $error("pointers disagree on empty queue");
`endif

endmodule

@@ rtl/c6502_back.sv @@
`timescale 1ns / 1ps
module c6502_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              uop_valid_i,
  output logic              uop_ready_o,
  input  c6502_pkg::uop_t   uop_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              store_valid_o,
  output logic [15:0]       store_address_o,
  output logic [7:0]        store_data_o,
  output logic              branch_taken_o,
  output logic [7:0]        a_out_o,
  output logic [7:0]        x_out_o,
  output logic [7:0]        y_out_o,
  output logic [7:0]        sp_out_o,
  output logic [7:0]        flags_out_o
);

  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic        ovalid_q;
  logic        st_q, st_d, br_q, br_d;
  logic [15:0] sta_q, sta_d;
  logic [7:0]  std_q, std_d;
  logic        fire;
  logic [7:0]  m, src, r, addend, cmp_reg;
  logic [8:0]  sum, diff;
  logic        zn_en;
  logic [7:0]  zn_val;

  // Take a new op whenever the output slot is free or being drained
  assign uop_ready_o = !ovalid_q || ready_i;
  assign fire        = uop_valid_i && uop_ready_o;

  assign m       = uop_i.operand;
  assign src     = uop_i.to_acc ? a_q : m;
  assign addend  = (uop_i.op == c6502_pkg::OpSbc) ? ~m : m;
  assign sum     = {1'b0, a_q} + {1'b0, addend} + {8'b0, p_q[c6502_pkg::FlagC]};
  assign cmp_reg = (uop_i.op == c6502_pkg::OpCpx) ? x_q :
                   (uop_i.op == c6502_pkg::OpCpy) ? y_q : a_q;
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};

  // Execute one op on the architectural registers
  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    st_d = 1'b0; sta_d = '0; std_d = '0; br_d = 1'b0;
    zn_en = 1'b0; zn_val = '0; r = '0;
    case (uop_i.op)
      c6502_pkg::OpAdc, c6502_pkg::OpSbc: begin
        a_d = sum[7:0];
        p_d[c6502_pkg::FlagC] = sum[8];
        p_d[c6502_pkg::FlagV] = (a_q[7] ^ sum[7]) & ~(a_q[7] ^ addend[7]);
        zn_en = 1'b1; zn_val = sum[7:0];
      end
      c6502_pkg::OpAnd: begin a_d = a_q & m; zn_en = 1'b1; zn_val = a_q & m; end
      c6502_pkg::OpEor: begin a_d = a_q ^ m; zn_en = 1'b1; zn_val = a_q ^ m; end
      c6502_pkg::OpOra: begin a_d = a_q | m; zn_en = 1'b1; zn_val = a_q | m; end
      c6502_pkg::OpAsl, c6502_pkg::OpLsr, c6502_pkg::OpRol, c6502_pkg::OpRor: begin
        case (uop_i.op)
          c6502_pkg::OpAsl: r = {src[6:0], 1'b0};
          c6502_pkg::OpLsr: r = {1'b0, src[7:1]};
          c6502_pkg::OpRol: r = {src[6:0], p_q[c6502_pkg::FlagC]};
          default:          r = {p_q[c6502_pkg::FlagC], src[7:1]};
        endcase
        p_d[c6502_pkg::FlagC] = (uop_i.op == c6502_pkg::OpAsl ||
                                 uop_i.op == c6502_pkg::OpRol) ? src[7] : src[0];
        zn_en = 1'b1; zn_val = r;
        if (uop_i.to_acc) begin
          a_d = r;
        end else begin
          st_d = 1'b1; sta_d = uop_i.addr; std_d = r;
        end
      end
      c6502_pkg::OpBcc: br_d = !p_q[c6502_pkg::FlagC];
      c6502_pkg::OpBcs: br_d = p_q[c6502_pkg::FlagC];
      c6502_pkg::OpBeq: br_d = p_q[c6502_pkg::FlagZ];
      c6502_pkg::OpBne: br_d = !p_q[c6502_pkg::FlagZ];
      c6502_pkg::OpBmi: br_d = p_q[c6502_pkg::FlagN];
      c6502_pkg::OpBpl: br_d = !p_q[c6502_pkg::FlagN];
      c6502_pkg::OpBvc: br_d = !p_q[c6502_pkg::FlagV];
      c6502_pkg::OpBvs: br_d = p_q[c6502_pkg::FlagV];
      c6502_pkg::OpBit: begin
        p_d[c6502_pkg::FlagZ] = (a_q & m) == 8'h00;
        p_d[c6502_pkg::FlagN] = m[7];
        p_d[c6502_pkg::FlagV] = m[6];
      end
      c6502_pkg::OpBrk: begin
        st_d  = 1'b1;
        sta_d = {c6502_pkg::StackPage, sp_q - 8'd2};
        std_d = p_q | 8'h14;
        sp_d  = sp_q - 8'd3;
        p_d[c6502_pkg::FlagI] = 1'b1;
        p_d[c6502_pkg::FlagB] = 1'b0;
      end
      c6502_pkg::OpClc: p_d[c6502_pkg::FlagC] = 1'b0;
      c6502_pkg::OpCld: p_d[c6502_pkg::FlagD] = 1'b0;
      c6502_pkg::OpCli: p_d[c6502_pkg::FlagI] = 1'b0;
      c6502_pkg::OpClv: p_d[c6502_pkg::FlagV] = 1'b0;
      c6502_pkg::OpSec: p_d[c6502_pkg::FlagC] = 1'b1;
      c6502_pkg::OpSed: p_d[c6502_pkg::FlagD] = 1'b1;
      c6502_pkg::OpSei: p_d[c6502_pkg::FlagI] = 1'b1;
      c6502_pkg::OpCmp, c6502_pkg::OpCpx, c6502_pkg::OpCpy: begin
        p_d[c6502_pkg::FlagC] = !diff[8];
        p_d[c6502_pkg::FlagZ] = diff[7:0] == 8'h00;
        p_d[c6502_pkg::FlagN] = diff[7];
      end
      c6502_pkg::OpDec, c6502_pkg::OpInc: begin
        r = (uop_i.op == c6502_pkg::OpDec) ? m - 8'd1 : m + 8'd1;
        zn_en = 1'b1; zn_val = r;
        st_d = 1'b1; sta_d = uop_i.addr; std_d = r;
      end
      c6502_pkg::OpDex: begin x_d = x_q - 8'd1; zn_en = 1'b1; zn_val = x_q - 8'd1; end
      c6502_pkg::OpDey: begin y_d = y_q - 8'd1; zn_en = 1'b1; zn_val = y_q - 8'd1; end
      c6502_pkg::OpInx: begin x_d = x_q + 8'd1; zn_en = 1'b1; zn_val = x_q + 8'd1; end
      c6502_pkg::OpIny: begin y_d = y_q + 8'd1; zn_en = 1'b1; zn_val = y_q + 8'd1; end
      c6502_pkg::OpJsr: sp_d = sp_q - 8'd2;
      c6502_pkg::OpLda: begin a_d = m; zn_en = 1'b1; zn_val = m; end
      c6502_pkg::OpLdx: begin x_d = m; zn_en = 1'b1; zn_val = m; end
      c6502_pkg::OpLdy: begin y_d = m; zn_en = 1'b1; zn_val = m; end
      c6502_pkg::OpPha: begin
        st_d = 1'b1; sta_d = {c6502_pkg::StackPage, sp_q}; std_d = a_q;
        sp_d = sp_q - 8'd1;
      end
      c6502_pkg::OpPhp: begin
        st_d = 1'b1; sta_d = {c6502_pkg::StackPage, sp_q};
        std_d = p_q | 8'h10;
        sp_d = sp_q - 8'd1;
        p_d[c6502_pkg::FlagB] = 1'b0;
      end
      c6502_pkg::OpPla: begin
        sp_d = sp_q + 8'd1; a_d = m; zn_en = 1'b1; zn_val = m;
      end
      c6502_pkg::OpPlp: begin sp_d = sp_q + 8'd1; p_d = m; end
      c6502_pkg::OpRti: begin sp_d = sp_q + 8'd3; p_d = m; end
      c6502_pkg::OpRts: sp_d = sp_q + 8'd2;
      c6502_pkg::OpSta: begin st_d = 1'b1; sta_d = uop_i.addr; std_d = a_q; end
      c6502_pkg::OpStx: begin st_d = 1'b1; sta_d = uop_i.addr; std_d = x_q; end
      c6502_pkg::OpSty: begin st_d = 1'b1; sta_d = uop_i.addr; std_d = y_q; end
      c6502_pkg::OpTax: begin x_d = a_q; zn_en = 1'b1; zn_val = a_q; end
      c6502_pkg::OpTay: begin y_d = a_q; zn_en = 1'b1; zn_val = a_q; end
      c6502_pkg::OpTsx: begin x_d = sp_q; zn_en = 1'b1; zn_val = sp_q; end
      c6502_pkg::OpTxa: begin a_d = x_q; zn_en = 1'b1; zn_val = x_q; end
      c6502_pkg::OpTya: begin a_d = y_q; zn_en = 1'b1; zn_val = y_q; end
      c6502_pkg::OpTxs: sp_d = x_q;
      default: ;
    endcase
    if (zn_en) begin
      p_d[c6502_pkg::FlagZ] = zn_val == 8'h00;
      p_d[c6502_pkg::FlagN] = zn_val[7];
    end
  end

  // Update registers and the output slot on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= c6502_pkg::AccReset;
      x_q      <= c6502_pkg::AccReset;
      y_q      <= c6502_pkg::AccReset;
      sp_q     <= c6502_pkg::SpReset;
      p_q      <= c6502_pkg::FlagsReset;
      ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
        ovalid_q <= 1'b1;
      end else if (ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      st_q <= st_d; sta_q <= sta_d; std_q <= std_d; br_q <= br_d;
    end
  end

  assign valid_o         = ovalid_q;
  assign store_valid_o   = st_q;
  assign store_address_o = sta_q;
  assign store_data_o    = std_q;
  assign branch_taken_o  = br_q;
  assign a_out_o         = a_q;
  assign x_out_o         = x_q;
  assign y_out_o         = y_q;
  assign sp_out_o        = sp_q;
  assign flags_out_o     = p_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !ready_i) |=> $stable(a_q) && $stable(p_q) && $stable(sp_q))
    else $error("registers changed while result stalled");
  a_br_nostore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !(st_q && br_q))
    else $error("branch and store reported together");
  a_idle_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(x_q) && $stable(y_q))
    else $error("index registers changed without an op");
`endif

endmodule

@@ rtl/cpu6502_execute_unit.sv @@
`timescale 1ns / 1ps
// Execute stage of a 6502 (binary arithmetic only). Each accepted op updates
// A, X, Y, SP and P and yields one result: the store to make, whether a branch
// is taken and the registers after the op. An op is taken every clock while
// the queue has room. The result appears in the cycle after the op leaves
// the two-entry front queue; an op passes the queue register, then the
// output register. Registers reset to A=X=Y=0, SP=FD, P=34.
module cpu6502_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [5:0]  mode_i,
  input  logic        to_accumulator_i,
  input  logic [7:0]  operand_i,
  input  logic [15:0] operand_address_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        store_valid_o,
  output logic [15:0] store_address_o,
  output logic [7:0]  store_data_o,
  output logic        branch_taken_o,
  output logic [7:0]  a_out_o,
  output logic [7:0]  x_out_o,
  output logic [7:0]  y_out_o,
  output logic [7:0]  sp_out_o,
  output logic [7:0]  flags_out_o
);

  c6502_pkg::uop_t uop;
  logic            uop_valid, uop_ready;

  c6502_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .mode_i, .to_accumulator_i,
    .operand_i, .operand_address_i,
    .uop_valid_o (uop_valid),
    .uop_ready_i (uop_ready),
    .uop_o       (uop)
  );

  c6502_back u_back (
    .clk_i, .rst_ni,
    .uop_valid_i (uop_valid),
    .uop_ready_o (uop_ready),
    .uop_i       (uop),
    .valid_o, .ready_i, .store_valid_o, .store_address_o, .store_data_o,
    .branch_taken_o, .a_out_o, .x_out_o, .y_out_o, .sp_out_o, .flags_out_o
  );

endmodule
